[rtl/mexp_pkg.sv]
// Package for the secp256k1 modular exponentiation block.
// Holds field widths, the prime, the sequencer state type and defaults; no dependencies.
`default_nettype none
package mexp_pkg;
    localparam int WORD_W      = 64;
    localparam int FIELD_W     = 256;
    localparam int IN_DATA_W   = 8 * WORD_W;
    localparam int OUT_DATA_W  = 4 * WORD_W;
    localparam int EXP_BITS_DEF = 256;

    localparam logic [FIELD_W-1:0] PRIME =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
    localparam logic [FIELD_W-1:0] FIELD_ONE = {{(FIELD_W-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT,
        ST_DONE
    } mexp_state_t;
endpackage
`default_nettype wire

[rtl/mexp_modmul.sv]
// Bit-serial interleaved modular multiplier over the secp256k1 prime.
// Depends on mexp_pkg for the field width and the prime.
`default_nettype none
module mexp_modmul
    import mexp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [FIELD_W-1:0] a,
    input  wire logic [FIELD_W-1:0] b,
    output logic                    done,
    output logic [FIELD_W-1:0]      r
);
    localparam int STEP_W = $clog2(FIELD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FIELD_W - 1);

    logic [FIELD_W-1:0] a_reg, a_next;
    logic [FIELD_W-1:0] b_reg, b_next;
    logic [FIELD_W-1:0] r_reg, r_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [FIELD_W+1:0] sum;
    logic [FIELD_W+1:0] red;

    // One step: r = 2r + a_msb*b, then bring it back below P (it is below 3P).
    always_comb
    begin
        sum = {1'b0, r_reg, 1'b0} + (a_reg[FIELD_W-1] ? {2'b00, b_reg} : '0);
        if (sum >= {1'b0, PRIME, 1'b0})
        begin
            red = sum - {1'b0, PRIME, 1'b0};
        end
        else if (sum >= {2'b00, PRIME})
        begin
            red = sum - {2'b00, PRIME};
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next   = {a_reg[FIELD_W-2:0], 1'b0};
            r_next   = red[FIELD_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign r    = r_reg;
endmodule
`default_nettype wire

[rtl/modular_exponentiation_256.sv]
// Top level of the secp256k1 modular exponentiation block.
// Depends on mexp_pkg and mexp_modmul.
//
// This block computes base to the power exponent modulo the secp256k1 prime
// 2^256 - 2^32 - 977 by right-to-left square-and-multiply over the low
// EXPONENT_BITS exponent bits. A base at or above the prime is reduced once on
// entry. Every exponent bit costs one multiply (by the base power or by one)
// and one squaring, regardless of its value, so the latency does not depend
// on the data. The two products of a bit run side by side on two bit-serial
// multipliers, which take one multiplier bit per cycle; one exponent bit
// therefore passes through a start state, 256 multiplier steps and a wait
// state that takes the products. The result becomes valid and the input
// side opens again in the same cycle. One transaction is worked on at a
// time; the result sits in an output register, so a new input transaction is
// taken as soon as the previous result has been parked, even if the
// downstream side has not yet collected it.
`default_nettype none
module modular_exponentiation_256
    import mexp_pkg::*;
#(
    parameter int EXPONENT_BITS = EXP_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // base_word_0..3 then exp_word_0..3, 64 bits each, lowest bits first
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // power_word_0..3, 64 bits each, lowest bits first
    output logic [OUT_DATA_W-1:0]      m_tdata
);
    localparam int CNT_W = $clog2(EXPONENT_BITS + 1);

    mexp_state_t state_reg, state_next;
    logic [FIELD_W-1:0]       acc_reg, acc_next;
    logic [FIELD_W-1:0]       power_reg, power_next;
    logic [EXPONENT_BITS-1:0] exp_reg, exp_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]       out_data_reg, out_data_next;

    logic [FIELD_W-1:0] base_in;
    logic [FIELD_W:0]   base_diff;
    logic               mul_start;
    logic               mul_done;
    logic               sq_done;
    logic [FIELD_W-1:0] mul_r;
    logic [FIELD_W-1:0] sq_r;
    logic [FIELD_W-1:0] factor;

    assign base_in   = s_tdata[FIELD_W-1:0];
    assign base_diff = {1'b0, base_in} - {1'b0, PRIME};
    assign factor    = exp_reg[0] ? power_reg : FIELD_ONE;

    // Multiplies the running result by the base power or by one.
    mexp_modmul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (acc_reg),
        .b     (factor),
        .done  (mul_done),
        .r     (mul_r)
    );

    // Squares the base power.
    mexp_modmul u_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (power_reg),
        .b     (power_reg),
        .done  (sq_done),
        .r     (sq_r)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        power_next     = power_reg;
        exp_next       = exp_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        s_tready       = 1'b0;
        mul_start      = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    // The borrow bit clear means base >= P.
                    power_next = base_diff[FIELD_W] ? base_in : base_diff[FIELD_W-1:0];
                    acc_next   = FIELD_ONE;
                    exp_next   = s_tdata[FIELD_W +: EXPONENT_BITS];
                    cnt_next   = CNT_W'(EXPONENT_BITS);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mul_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_done && sq_done)
                begin
                    acc_next   = mul_r;
                    power_next = sq_r;
                    exp_next   = exp_reg >> 1;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = (cnt_reg == CNT_W'(1)) ? ST_DONE : ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        power_reg    <= power_next;
        exp_reg      <= exp_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule
`default_nettype wire

[rtl/mexp_checker.sv]
// Port-level checker for modular_exponentiation_256, bound to the top level.
// Depends on mexp_pkg for widths and the prime.
`default_nettype none
module mexp_checker
    import mexp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);
    // A taken transaction keeps the input side closed while it is worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 !s_tready)
        else $error("input accepted again too soon");

    // Results are always fully reduced.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata < PRIME))
        else $error("result not reduced below the prime");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // The input side is never open on the cycle after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input side open directly after accept");
endmodule

bind modular_exponentiation_256 mexp_checker u_mexp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
